### rtl/sed_pkg.sv
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types and constants for the speech endpoint detector: the item
// structs, the register set and the register indexes.
// ----------------------------------------------------------------------------
package sed_pkg;

  // Largest frame length that is counted; longer frames are clamped.
  localparam logic [12:0] MAX_FRAME = 13'd4096;

  // Configuration port widths.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_PROB_THRESHOLD  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_SILENCE     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_SPEECH      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PRE_ROLL_CAP    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_CONSEC      = 3'd4;

  // Register reset values.
  localparam logic [15:0] RST_PROB_THRESHOLD = 16'd32768;
  localparam logic [23:0] RST_MIN_SILENCE    = 24'd12800;
  localparam logic [23:0] RST_MIN_SPEECH     = 24'd4000;
  localparam logic [15:0] RST_PRE_ROLL_CAP   = 16'd4800;
  localparam logic [7:0]  RST_MIN_CONSEC     = 8'd3;

  // Saturation limits.
  localparam logic [7:0]  CONSEC_MAX = 8'hFF;
  localparam logic [23:0] SAT24      = 24'hFF_FFFF;
  localparam logic [31:0] SAT32      = 32'hFFFF_FFFF;

  // One audio frame.
  typedef struct packed {
    logic [15:0] voice_prob;
    logic [12:0] frame_samples;
  } in_item_t;

  // One per-frame result.
  typedef struct packed {
    logic        speech_flag;
    logic        in_utterance;
    logic        utterance_started;
    logic [15:0] pre_roll_taken;
    logic        utterance_done;
    logic        utterance_kept;
    logic [31:0] utterance_length;
    logic [23:0] trailing_silence;
  } out_item_t;

  // Current register set.
  typedef struct packed {
    logic [15:0] prob_threshold;
    logic [23:0] min_silence_samples;
    logic [23:0] min_speech_samples;
    logic [15:0] pre_roll_cap_samples;
    logic [7:0]  min_consec_speech;
  } cfg_t;

endpackage

### rtl/sed_cfg_regs.sv
// ----------------------------------------------------------------------------
// sed_cfg_regs
// Configuration register file. Writes are always taken; an unknown index
// leaves every register unchanged.
// ----------------------------------------------------------------------------
module sed_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sed_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sed_pkg::CFG_DATA_W-1:0]     cfg_data,
  output sed_pkg::cfg_t                      cfg
);

  assign cfg_ready = 1'b1;

  // Register writes, truncated to each register's width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prob_threshold       <= sed_pkg::RST_PROB_THRESHOLD;
      cfg.min_silence_samples  <= sed_pkg::RST_MIN_SILENCE;
      cfg.min_speech_samples   <= sed_pkg::RST_MIN_SPEECH;
      cfg.pre_roll_cap_samples <= sed_pkg::RST_PRE_ROLL_CAP;
      cfg.min_consec_speech    <= sed_pkg::RST_MIN_CONSEC;
    end else if (cfg_valid) begin
      case (cfg_index)
        sed_pkg::REG_PROB_THRESHOLD: cfg.prob_threshold       <= cfg_data[15:0];
        sed_pkg::REG_MIN_SILENCE:    cfg.min_silence_samples  <= cfg_data[23:0];
        sed_pkg::REG_MIN_SPEECH:     cfg.min_speech_samples   <= cfg_data[23:0];
        sed_pkg::REG_PRE_ROLL_CAP:   cfg.pre_roll_cap_samples <= cfg_data[15:0];
        sed_pkg::REG_MIN_CONSEC:     cfg.min_consec_speech    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/sed_tracker.sv
// ----------------------------------------------------------------------------
// sed_tracker
// Utterance state and its one-frame update. The result for the frame held in
// the input register is formed combinationally; the state moves on step.
// ----------------------------------------------------------------------------
module sed_tracker (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  sed_pkg::in_item_t   item,
  input  sed_pkg::cfg_t       cfg,
  output sed_pkg::out_item_t  result
);

  // Utterance state.
  logic        active;
  logic [7:0]  consec_count;
  logic [23:0] speech_total;
  logic [23:0] silence_total;
  logic [15:0] pre_roll_level;
  logic [31:0] length_total;

  logic        active_next;
  logic [7:0]  consec_count_next;
  logic [23:0] speech_total_next;
  logic [23:0] silence_total_next;
  logic [15:0] pre_roll_level_next;
  logic [31:0] length_total_next;

  logic [12:0] n;
  logic        speech;
  logic        confirmed;
  logic        started;
  logic        active_mid;
  logic        ended;
  logic [7:0]  consec_upd;
  logic [23:0] speech_base;
  logic [24:0] speech_sum;
  logic [23:0] speech_upd;
  logic [24:0] silence_sum;
  logic [23:0] silence_upd;
  logic [31:0] length_base;
  logic [32:0] length_sum;
  logic [31:0] length_upd;
  logic [16:0] pre_roll_sum;
  logic [15:0] pre_roll_upd;

  // Frame length clamp, threshold and run counter.
  always_comb begin
    n = (item.frame_samples > sed_pkg::MAX_FRAME) ? sed_pkg::MAX_FRAME
                                                  : item.frame_samples;
    speech = (item.voice_prob >= cfg.prob_threshold);
    if (!speech) begin
      consec_upd = 8'd0;
    end else if (consec_count != sed_pkg::CONSEC_MAX) begin
      consec_upd = consec_count + 8'd1;
    end else begin
      consec_upd = consec_count;
    end
    confirmed  = active ? (consec_upd >= cfg.min_consec_speech) : speech;
    started    = confirmed && !active;
    active_mid = active || confirmed;
  end

  // Saturating accumulators.
  always_comb begin
    speech_base = started ? 24'd0 : speech_total;
    speech_sum  = {1'b0, speech_base} + {12'd0, n};
    if (!confirmed) begin
      speech_upd = speech_total;
    end else if (speech_sum[24]) begin
      speech_upd = sed_pkg::SAT24;
    end else begin
      speech_upd = speech_sum[23:0];
    end

    silence_sum = {1'b0, silence_total} + {12'd0, n};
    if (confirmed) begin
      silence_upd = 24'd0;
    end else if (!active) begin
      silence_upd = silence_total;
    end else if (silence_sum[24]) begin
      silence_upd = sed_pkg::SAT24;
    end else begin
      silence_upd = silence_sum[23:0];
    end

    length_base = started ? {16'd0, pre_roll_level} : length_total;
    length_sum  = {1'b0, length_base} + {20'd0, n};
    if (!active_mid) begin
      length_upd = length_total;
    end else if (length_sum[32]) begin
      length_upd = sed_pkg::SAT32;
    end else begin
      length_upd = length_sum[31:0];
    end

    pre_roll_sum = {1'b0, pre_roll_level} + {4'd0, n};
    if (active_mid) begin
      pre_roll_upd = 16'd0;
    end else if (pre_roll_sum > {1'b0, cfg.pre_roll_cap_samples}) begin
      pre_roll_upd = cfg.pre_roll_cap_samples;
    end else begin
      pre_roll_upd = pre_roll_sum[15:0];
    end

    ended = active_mid && (silence_upd >= cfg.min_silence_samples);
  end

  // Next state: an end clears the whole utterance.
  always_comb begin
    if (ended) begin
      active_next         = 1'b0;
      consec_count_next   = 8'd0;
      speech_total_next   = 24'd0;
      silence_total_next  = 24'd0;
      pre_roll_level_next = 16'd0;
      length_total_next   = 32'd0;
    end else begin
      active_next         = active_mid;
      consec_count_next   = consec_upd;
      speech_total_next   = speech_upd;
      silence_total_next  = silence_upd;
      pre_roll_level_next = pre_roll_upd;
      length_total_next   = length_upd;
    end
  end

  // Result fields for this frame.
  always_comb begin
    result.speech_flag       = speech;
    result.in_utterance      = active_next;
    result.utterance_started = started;
    result.pre_roll_taken    = started ? pre_roll_level : 16'd0;
    result.utterance_done    = ended;
    result.utterance_kept    = ended && (speech_upd >= cfg.min_speech_samples);
    result.utterance_length  = active_mid ? length_upd : 32'd0;
    result.trailing_silence  = silence_total_next;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      consec_count   <= 8'd0;
      speech_total   <= 24'd0;
      silence_total  <= 24'd0;
      pre_roll_level <= 16'd0;
      length_total   <= 32'd0;
    end else if (step) begin
      active         <= active_next;
      consec_count   <= consec_count_next;
      speech_total   <= speech_total_next;
      silence_total  <= silence_total_next;
      pre_roll_level <= pre_roll_level_next;
      length_total   <= length_total_next;
    end
  end

endmodule

### rtl/speech_endpoint_detector_top.sv
// ----------------------------------------------------------------------------
// speech_endpoint_detector_top
// Speech endpoint detector: thresholds per-frame speech probabilities and
// tracks utterance start, hangover silence, pre-roll and utterance length.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_ready   in_item   (voice_prob, frame_samples)
//   out      out_valid / out_ready out_item  (eight result fields)
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
// A frame is taken into the input register and, once the output register
// is free or being taken, its result moves there as the utterance state
// updates. One frame per cycle is sustained while the output is not stalled.
// A frame of zero samples is dropped with no result. A stalled output holds one
// more frame in the input register and then drops in_ready. Synchronous reset
// empties both registers and restores the state and configuration defaults.
// ----------------------------------------------------------------------------
module speech_endpoint_detector_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  sed_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output sed_pkg::out_item_t              out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sed_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sed_pkg::CFG_DATA_W-1:0]  cfg_data
);

  sed_pkg::cfg_t      cfg;
  sed_pkg::in_item_t  in_reg;
  sed_pkg::out_item_t result;
  logic               in_full;
  logic               advance;
  logic               step;

  sed_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The held frame moves on when the output register is free or being taken.
  assign advance  = in_full && (!out_valid || out_ready);
  assign step     = advance && (in_reg.frame_samples != 13'd0);
  assign in_ready = !in_full || advance;

  sed_tracker u_tracker (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_reg),
    .cfg    (cfg),
    .result (result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_item;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item <= result;
    end
  end

endmodule

### tb/sed_checker.sv
// ----------------------------------------------------------------------------
// speech_endpoint_checker
// Passive checker for the speech endpoint detector. It follows register
// writes and accepted frames, keeps its own copy of the utterance tracking
// state, predicts one result per non-empty frame and compares every accepted
// result, field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module speech_endpoint_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  sed_pkg::in_item_t               in_item,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  sed_pkg::out_item_t              out_item,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [sed_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sed_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              results_checked,
  output int                              utterances_closed,
  output int                              utterances_kept
);

  timeunit 1ns;
  timeprecision 1ps;

  // At most two frames are ever in flight inside the block.
  localparam int PRED_DEPTH = 8;

  // Register shadow and utterance tracking state.
  sed_pkg::cfg_t regs;
  logic          in_utt;
  logic [7:0]    run_len;
  logic [23:0]   speech_len;
  logic [23:0]   silence_len;
  logic [15:0]   pre_roll;
  logic [31:0]   utt_len;

  // Predicted results, oldest first, in a small ring.
  sed_pkg::out_item_t pred_fifo [PRED_DEPTH];
  int                 pred_wr;
  int                 pred_rd;

  // Add two counts and stop at the given ceiling.
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] cap);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return (sum > {1'b0, cap}) ? cap : sum[31:0];
  endfunction

  // Advance the tracking state by one non-empty frame and return its result.
  function automatic sed_pkg::out_item_t advance_detector(input sed_pkg::in_item_t frame);
    sed_pkg::out_item_t res;
    logic [12:0]        n;
    logic               speech;
    logic               confirmed;
    res = '0;
    n = (frame.frame_samples > sed_pkg::MAX_FRAME) ? sed_pkg::MAX_FRAME
                                                   : frame.frame_samples;
    speech = frame.voice_prob >= regs.prob_threshold;
    if (speech) begin
      if (run_len != sed_pkg::CONSEC_MAX) run_len = run_len + 8'd1;
    end else begin
      run_len = '0;
    end
    // Outside an utterance any speech frame opens one; inside, only a run does.
    confirmed = in_utt ? (run_len >= regs.min_consec_speech) : speech;
    if (confirmed) begin
      if (!in_utt) begin
        in_utt = 1'b1;
        res.utterance_started = 1'b1;
        res.pre_roll_taken = pre_roll;
        speech_len = '0;
        utt_len = {16'd0, pre_roll};
      end
      speech_len = 24'(sat_add(32'(speech_len), 32'(n), 32'(sed_pkg::SAT24)));
      silence_len = '0;
    end else if (in_utt) begin
      silence_len = 24'(sat_add(32'(silence_len), 32'(n), 32'(sed_pkg::SAT24)));
    end
    if (in_utt) begin
      utt_len = sat_add(utt_len, 32'(n), sed_pkg::SAT32);
      pre_roll = '0;
    end else begin
      pre_roll = 16'(sat_add(32'(pre_roll), 32'(n), 32'(regs.pre_roll_cap_samples)));
    end
    res.utterance_length = in_utt ? utt_len : '0;
    // Enough trailing silence closes the utterance and clears the counts.
    if (in_utt && silence_len >= regs.min_silence_samples) begin
      res.utterance_done = 1'b1;
      res.utterance_kept = speech_len >= regs.min_speech_samples;
      in_utt = 1'b0;
      silence_len = '0;
      speech_len = '0;
      utt_len = '0;
      pre_roll = '0;
      run_len = '0;
    end
    res.speech_flag = speech;
    res.in_utterance = in_utt;
    res.trailing_silence = silence_len;
    return res;
  endfunction

  // Report one field that differs from its prediction.
  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endtask

  // Follow the three channels at every rising edge.
  always @(posedge clk) begin
    sed_pkg::out_item_t want;
    if (rst) begin
      regs.prob_threshold       = sed_pkg::RST_PROB_THRESHOLD;
      regs.min_silence_samples  = sed_pkg::RST_MIN_SILENCE;
      regs.min_speech_samples   = sed_pkg::RST_MIN_SPEECH;
      regs.pre_roll_cap_samples = sed_pkg::RST_PRE_ROLL_CAP;
      regs.min_consec_speech    = sed_pkg::RST_MIN_CONSEC;
      in_utt = 1'b0;
      run_len = '0;
      speech_len = '0;
      silence_len = '0;
      pre_roll = '0;
      utt_len = '0;
      pred_wr = 0;
      pred_rd = 0;
      fail_count = 0;
      results_checked = 0;
      utterances_closed = 0;
      utterances_kept = 0;
    end else begin
      // Register writes; unknown indexes are dropped.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sed_pkg::REG_PROB_THRESHOLD: regs.prob_threshold = cfg_data[15:0];
          sed_pkg::REG_MIN_SILENCE:    regs.min_silence_samples = cfg_data;
          sed_pkg::REG_MIN_SPEECH:     regs.min_speech_samples = cfg_data;
          sed_pkg::REG_PRE_ROLL_CAP:   regs.pre_roll_cap_samples = cfg_data[15:0];
          sed_pkg::REG_MIN_CONSEC:     regs.min_consec_speech = cfg_data[7:0];
          default: ;
        endcase
      end
      // Results are matched before this edge's frame is predicted, since a
      // frame's result can never leave on the edge that accepts the frame.
      if (out_valid && out_ready) begin
        if (pred_wr == pred_rd) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual 0x%0h", $time, out_item);
        end else begin
          want = pred_fifo[pred_rd % PRED_DEPTH];
          pred_rd++;
          check_field("speech_flag", 32'(want.speech_flag), 32'(out_item.speech_flag));
          check_field("in_utterance", 32'(want.in_utterance), 32'(out_item.in_utterance));
          check_field("utterance_started", 32'(want.utterance_started),
                      32'(out_item.utterance_started));
          check_field("pre_roll_taken", 32'(want.pre_roll_taken),
                      32'(out_item.pre_roll_taken));
          check_field("utterance_done", 32'(want.utterance_done),
                      32'(out_item.utterance_done));
          check_field("utterance_kept", 32'(want.utterance_kept),
                      32'(out_item.utterance_kept));
          check_field("utterance_length", want.utterance_length, out_item.utterance_length);
          check_field("trailing_silence", 32'(want.trailing_silence),
                      32'(out_item.trailing_silence));
          results_checked++;
          if (want.utterance_done) utterances_closed++;
          if (want.utterance_kept) utterances_kept++;
        end
      end
      // Empty frames produce nothing and leave the state alone.
      if (in_valid && in_ready && in_item.frame_samples != '0) begin
        pred_fifo[pred_wr % PRED_DEPTH] = advance_detector(in_item);
        pred_wr++;
      end
    end
    pending <= pred_wr - pred_rd;
  end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Regression for the speech endpoint detector. A short directed run covers
// empty and oversized frames, pre-roll capping, start and end on one frame,
// the never-ending utterance and the register extremes; then random phases
// of utterance-shaped frame sequences and noise run under several register
// settings and idle patterns. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 4;
  localparam logic [sed_pkg::CFG_INDEX_W-1:0] REG_UNUSED_LO = 3'd5;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  sed_pkg::in_item_t               in_item = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  sed_pkg::out_item_t              out_item;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [sed_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [sed_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  int fail_count;
  int pending;
  int results_checked;
  int utterances_closed;
  int utterances_kept;

  // Stimulus controls.
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          frames_sent = 0;
  int          settings_loaded = 0;
  int          quiet_cycles = 0;
  logic [15:0] cur_thr = sed_pkg::RST_PROB_THRESHOLD;
  logic [23:0] cur_sil = sed_pkg::RST_MIN_SILENCE;

  always #2 clk = ~clk;

  speech_endpoint_detector_top dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  speech_endpoint_checker checker_i (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_item          (in_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_item         (out_item),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending          (pending),
    .results_checked  (results_checked),
    .utterances_closed(utterances_closed),
    .utterances_kept  (utterances_kept)
  );

  // The result side stalls at random at the current rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Count cycles in which no channel moves an item.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog.
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("speech_endpoint_detector_top regression: fail");
    $finish;
  end

  // Offer one frame, with random idle cycles ahead of it.
  task automatic send_frame(input logic [15:0] prob, input logic [12:0] n);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= {prob, n};
    do @(posedge clk); while (!in_ready);
    if (n != '0) frames_sent++;
  endtask

  // Stop sending and wait until every predicted result has come out.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sed_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Load a full register set while idle, plus one write to an unused index.
  task automatic load_registers(input sed_pkg::cfg_t c);
    wait_quiet();
    write_reg(sed_pkg::REG_PROB_THRESHOLD, {8'($urandom), c.prob_threshold});
    write_reg(sed_pkg::REG_MIN_SILENCE, c.min_silence_samples);
    write_reg(sed_pkg::REG_MIN_SPEECH, c.min_speech_samples);
    write_reg(sed_pkg::REG_PRE_ROLL_CAP, {8'($urandom), c.pre_roll_cap_samples});
    write_reg(sed_pkg::REG_MIN_CONSEC, {16'($urandom), c.min_consec_speech});
    write_reg(REG_UNUSED_LO + 3'($urandom_range(2)), 24'($urandom));
    cfg_valid <= 1'b0;
    cur_thr = c.prob_threshold;
    cur_sil = c.min_silence_samples;
    settings_loaded++;
  endtask

  function automatic sed_pkg::cfg_t make_cfg(input logic [15:0] thr,
                                             input logic [23:0] sil,
                                             input logic [23:0] spc,
                                             input logic [15:0] cap,
                                             input logic [7:0] consec);
    sed_pkg::cfg_t c;
    c.prob_threshold = thr;
    c.min_silence_samples = sil;
    c.min_speech_samples = spc;
    c.pre_roll_cap_samples = cap;
    c.min_consec_speech = consec;
    return c;
  endfunction

  function automatic logic [15:0] speech_level();
    return 16'($urandom_range(65535, cur_thr));
  endfunction

  // With a zero threshold nothing is silence, so any value will do.
  function automatic logic [15:0] quiet_level();
    return (cur_thr == '0) ? 16'($urandom) : 16'($urandom_range(cur_thr - 1, 0));
  endfunction

  // Mostly ordinary lengths, with a few empty and oversized frames.
  function automatic logic [12:0] frame_len(input int unsigned lo);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return '0;
    if (r < 7) return 13'($urandom_range(8191, 4097));
    if (r < 15) return 13'($urandom_range(4096, 1));
    return 13'($urandom_range(4096, lo));
  endfunction

  // Lead-in silence, a talk spurt with dips, then a silence tail that
  // usually reaches the limit and sometimes breaks off early.
  task automatic utterance_pattern();
    int unsigned k;
    int unsigned talk;
    logic [12:0] n;
    logic [24:0] tail;
    repeat ($urandom_range(3)) send_frame(quiet_level(), frame_len(64));
    talk = $urandom_range(8, 1);
    for (k = 0; k < talk; k++) begin
      if ($urandom_range(99) < 15) send_frame(quiet_level(), frame_len(32));
      else send_frame(speech_level(), frame_len(32));
    end
    tail = '0;
    k = 0;
    while (tail <= cur_sil && k < 40) begin
      if ($urandom_range(99) < 4) break;
      n = frame_len(256);
      send_frame(quiet_level(), n);
      tail += 25'((n > sed_pkg::MAX_FRAME) ? sed_pkg::MAX_FRAME : n);
      k++;
    end
  endtask

  // One random phase under one register set and one idle pattern.
  task automatic run_phase(input sed_pkg::cfg_t c, input int gap, input int stall,
                           input int frames);
    int target;
    int unsigned r;
    load_registers(c);
    gap_pct = gap;
    stall_pct = stall;
    target = frames_sent + frames;
    while (frames_sent < target) begin
      r = $urandom_range(99);
      if (r < 75) utterance_pattern();
      else if (r < 97) send_frame(16'($urandom), 13'($urandom));
      else wait_quiet();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames under the reset settings: an empty frame, pre-roll
    // capping, an oversized frame, a start that takes the pre-roll, a speech run
    // that meets the run requirement, then a discarded and a kept utterance.
    send_frame(16'hFFFF, 13'd0);
    send_frame(16'h0000, 13'd4096);
    send_frame(16'd32767, 13'h1FFF);
    send_frame(16'd32768, 13'd1);
    send_frame(16'h0000, 13'd4096);
    repeat (3) send_frame(16'hFFFF, 13'd2048);
    repeat (4) send_frame(16'h0000, 13'd4097);
    send_frame(16'd40000, 13'd4096);
    repeat (4) send_frame(16'd1, 13'd4096);

    // Zero silence limit, zero pre-roll cap, top threshold: an utterance
    // opens and closes on the same frame.
    load_registers(make_cfg(16'hFFFF, 24'd0, 24'd0, 16'd0, 8'd0));
    send_frame(16'hFFFE, 13'd100);
    send_frame(16'hFFFF, 13'd100);

    // Zero run requirement: once open, the utterance cannot end.
    load_registers(make_cfg(16'd1, 24'd100, 24'hFF_FFFF, 16'd16, 8'd0));
    send_frame(16'd0, 13'd50);
    send_frame(16'd1, 13'd50);
    repeat (2) send_frame(16'd0, 13'd4096);

    // Random phases over several settings and idle patterns.
    run_phase(make_cfg(sed_pkg::RST_PROB_THRESHOLD, sed_pkg::RST_MIN_SILENCE,
                       sed_pkg::RST_MIN_SPEECH, sed_pkg::RST_PRE_ROLL_CAP,
                       sed_pkg::RST_MIN_CONSEC), 0, 0, 40);
    run_phase(make_cfg(16'($urandom_range(64000, 1000)), 24'($urandom_range(6000, 1000)),
                       24'($urandom_range(6000)), 16'($urandom),
                       8'($urandom_range(4, 1))), 72, 0, 40);
    run_phase(make_cfg(16'($urandom_range(60000, 5000)), 24'($urandom_range(4000, 1500)),
                       24'hFF_FFFF, 16'($urandom), 8'($urandom_range(2, 1))), 0, 72, 40);
    run_phase(make_cfg(16'($urandom_range(45000, 20000)), 24'($urandom_range(800)),
                       24'($urandom_range(3000)), 16'hFFFF, 8'd1), 34, 34, 40);
    // Every frame is speech and the run requirement is at its top, so the
    // run counter has to stop at its ceiling rather than wrap.
    run_phase(make_cfg(16'd0, 24'hFF_FFFF, 24'($urandom), 16'($urandom), 8'hFF),
              0, 0, 265);

    wait_quiet();
    $display("Covered %0d frames under %0d register settings; %0d results checked.",
             frames_sent, settings_loaded, results_checked);
    $display("Utterances closed: %0d, of which kept: %0d.", utterances_closed,
             utterances_kept);
    if (fail_count == 0 && pending == 0) begin
      $display("speech_endpoint_detector_top regression: pass");
    end else begin
      $display("speech_endpoint_detector_top regression: fail");
    end
    $finish;
  end

endmodule
